>>> rtl/aic_pkg.sv
// aic_pkg: shared constants, types and address helpers for the integral
// contraction unit. No dependencies; every other file but aic_ram imports it.
package aic_pkg;

    localparam int BASIS_SIZE = 8;
    localparam int FRAC_BITS  = 16;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 4;
    localparam int OP_W   = 2;

    localparam int B2 = BASIS_SIZE * BASIS_SIZE;
    localparam int B4 = B2 * B2;

    localparam int SEL_W = ($clog2(BASIS_SIZE) > IDX_W) ? $clog2(BASIS_SIZE) : IDX_W;
    localparam int CMP_W = SEL_W + 1;
    localparam int K_AW  = $clog2(B4);
    localparam int SQ_AW = $clog2(B2);

    // T in the lower half, F in the upper half of one shared memory
    localparam int TF_AW    = SQ_AW + 1;
    localparam int TF_DEPTH = 1 << TF_AW;

    // diff and tsum carry one growth bit, product doubles that, x2 adds one,
    // the sum over B2 terms adds clog2(B2), one spare bit for rounding
    localparam int OPD_W  = DATA_W + 1;
    localparam int PROD_W = 2 * OPD_W;
    localparam int ACC_W  = PROD_W + 2 + $clog2(B2);

    // register after the last issue before the accumulator is final
    localparam int DRAIN_CYCLES = 3;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

    localparam logic [CFG_W-1:0] BASIS_RESET = CFG_W'(8);

    // APB map
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_BASIS = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_K = 2'd0,
        OP_WRITE_T = 2'd1,
        OP_WRITE_F = 2'd2,
        OP_COMPUTE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_ROUND,
        ST_ADDF,
        ST_DONE
    } state_t;

    // sequencer to datapath controls
    typedef struct packed {
        logic clear;
        logic issue;
        logic round_en;
        logic addf_en;
    } ctl_t;

    function automatic logic [K_AW-1:0] k_addr(input logic [SEL_W-1:0] a,
                                               input logic [SEL_W-1:0] b,
                                               input logic [SEL_W-1:0] c,
                                               input logic [SEL_W-1:0] d);
        logic [K_AW-1:0] r;
        r = K_AW'(a);
        r = K_AW'(r * K_AW'(BASIS_SIZE)) + K_AW'(b);
        r = K_AW'(r * K_AW'(BASIS_SIZE)) + K_AW'(c);
        r = K_AW'(r * K_AW'(BASIS_SIZE)) + K_AW'(d);
        return r;
    endfunction

    function automatic logic [SQ_AW-1:0] sq_addr(input logic [SEL_W-1:0] row,
                                                 input logic [SEL_W-1:0] col);
        logic [SQ_AW-1:0] r;
        r = SQ_AW'(SQ_AW'(row) * SQ_AW'(BASIS_SIZE)) + SQ_AW'(col);
        return r;
    endfunction

endpackage

>>> rtl/aic_if.sv
// aic_if: valid/ready channel interfaces for request and result items.
// Depends on aic_pkg for field widths.
interface aic_req_if import aic_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [IDX_W-1:0]         index_a;
    logic [IDX_W-1:0]         index_b;
    logic [IDX_W-1:0]         index_c;
    logic [IDX_W-1:0]         index_d;
    logic signed [DATA_W-1:0] data_value;

    modport source (output valid, operation, index_a, index_b, index_c, index_d,
                    data_value, input ready);
    modport sink   (input valid, operation, index_a, index_b, index_c, index_d,
                    data_value, output ready);
endinterface

interface aic_rsp_if import aic_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                     saturated;

    modport source (output valid, out_row, out_col, out_value, saturated, input ready);
    modport sink   (input valid, out_row, out_col, out_value, saturated, output ready);
endinterface

>>> rtl/aic_ram.sv
// aic_ram: generic RAM, one write port, two registered read ports.
// No dependencies.
module aic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

>>> rtl/aic_mac.sv
// aic_mac: contraction datapath - difference/sum, multiply, accumulate,
// round, add F and saturate. Depends on aic_pkg.
module aic_mac import aic_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctl_t                     ctl,
    input  logic [DATA_W-1:0]        k0,
    input  logic [DATA_W-1:0]        k1,
    input  logic [DATA_W-1:0]        t0,
    input  logic [DATA_W-1:0]        t1,
    input  logic [DATA_W-1:0]        f_in,
    output logic [DATA_W-1:0]        wb_value,
    output logic                     wb_sat
);

    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [OPD_W-1:0]  diff_reg, tsum_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, rnd_reg, sum_reg;
    logic signed [ACC_W-1:0]  term, rnd_pre, f_ext;
    logic                     all_zero, all_one;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // x2 folded in as a left shift
    assign term    = {{(ACC_W-PROD_W-1){prod_reg[PROD_W-1]}}, prod_reg, 1'b0};
    assign rnd_pre = acc_reg + (ACC_W'(1) << (FRAC_BITS - 1));
    assign f_ext   = {{(ACC_W-DATA_W){f_in[DATA_W-1]}}, f_in};

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            diff_reg <= $signed({k0[DATA_W-1], k0}) - $signed({k1[DATA_W-1], k1});
            tsum_reg <= $signed({t0[DATA_W-1], t0}) + $signed({t1[DATA_W-1], t1});
        end
        if (v2_reg)
        begin
            prod_reg <= diff_reg * tsum_reg;
        end
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (v3_reg)
        begin
            acc_reg <= acc_reg + term;
        end
        if (ctl.round_en)
        begin
            rnd_reg <= rnd_pre >>> FRAC_BITS;
        end
        if (ctl.addf_en)
        begin
            sum_reg <= rnd_reg + f_ext;
        end
    end

    // fits in 32 bits when all bits from the sign of the word upward agree
    assign all_zero = (sum_reg[ACC_W-1:DATA_W-1] == '0);
    assign all_one  = (sum_reg[ACC_W-1:DATA_W-1] == '1);

    always_comb
    begin
        wb_sat = !(all_zero || all_one);
        if (!wb_sat)
        begin
            wb_value = sum_reg[DATA_W-1:0];
        end
        else if (sum_reg[ACC_W-1])
        begin
            wb_value = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            wb_value = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

endmodule

>>> rtl/aic_ctrl.sv
// aic_ctrl: request handling, memory addressing and the pair sequencer.
// Depends on aic_pkg and aic_if.
module aic_ctrl import aic_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CFG_W-1:0]  basis,
    aic_req_if.sink           req,
    input  logic              out_free,
    input  logic [DATA_W-1:0] wb_value,
    output ctl_t              ctl,
    output logic              commit,
    output logic [IDX_W-1:0]  row,
    output logic [IDX_W-1:0]  col,
    output logic              k_we,
    output logic [K_AW-1:0]   k_waddr,
    output logic [K_AW-1:0]   k_raddr0,
    output logic [K_AW-1:0]   k_raddr1,
    output logic              t_we,
    output logic [SQ_AW-1:0]  t_waddr,
    output logic [SQ_AW-1:0]  t_raddr0,
    output logic [SQ_AW-1:0]  t_raddr1,
    output logic              f_we,
    output logic              f_re,
    output logic [SQ_AW-1:0]  f_waddr,
    output logic [DATA_W-1:0] f_wdata,
    output logic [SQ_AW-1:0]  f_raddr
);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     u_reg, u_next, l_reg, l_next;
    logic [CMP_W-1:0]     m_reg, m_next;
    logic [SEL_W-1:0]     v_reg, v_next, s_reg, s_next;
    logic [DRAIN_W-1:0]   drain_reg, drain_next;

    op_t                  op;
    logic [CMP_W-1:0]     m_cfg, a_ext, b_ext, c_ext, d_ext;
    logic                 ab_ok, cd_ok;
    logic [SEL_W-1:0]     a_sel, b_sel, c_sel, d_sel, u_sel, l_sel;
    logic                 s_last, v_last;

    assign op     = op_t'(req.operation);
    assign m_cfg  = (CMP_W'(basis) > CMP_W'(BASIS_SIZE)) ? CMP_W'(BASIS_SIZE)
                                                         : CMP_W'(basis);
    assign a_ext  = CMP_W'(req.index_a);
    assign b_ext  = CMP_W'(req.index_b);
    assign c_ext  = CMP_W'(req.index_c);
    assign d_ext  = CMP_W'(req.index_d);
    assign ab_ok  = (a_ext < CMP_W'(BASIS_SIZE)) && (b_ext < CMP_W'(BASIS_SIZE));
    assign cd_ok  = (c_ext < CMP_W'(BASIS_SIZE)) && (d_ext < CMP_W'(BASIS_SIZE));
    assign a_sel  = SEL_W'(req.index_a);
    assign b_sel  = SEL_W'(req.index_b);
    assign c_sel  = SEL_W'(req.index_c);
    assign d_sel  = SEL_W'(req.index_d);
    assign u_sel  = SEL_W'(u_reg);
    assign l_sel  = SEL_W'(l_reg);
    assign s_last = (CMP_W'(s_reg) + CMP_W'(1)) == m_reg;
    assign v_last = (CMP_W'(v_reg) + CMP_W'(1)) == m_reg;

    assign row = u_reg;
    assign col = l_reg;

    // compute reads: K[u,v,l,s], K[u,s,l,v], T[v,s], T[s,v]
    assign k_waddr  = k_addr(a_sel, b_sel, c_sel, d_sel);
    assign k_raddr0 = k_addr(u_sel, v_reg, l_sel, s_reg);
    assign k_raddr1 = k_addr(u_sel, s_reg, l_sel, v_reg);
    assign t_waddr  = sq_addr(a_sel, b_sel);
    assign t_raddr0 = sq_addr(v_reg, s_reg);
    assign t_raddr1 = sq_addr(s_reg, v_reg);
    assign f_raddr  = sq_addr(a_sel, b_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= '0;
            v_reg     <= '0;
            s_reg     <= '0;
            m_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
            v_reg     <= v_next;
            s_reg     <= s_next;
            m_reg     <= m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        l_reg <= l_next;
    end

    always_comb
    begin
        state_next = state_reg;
        u_next     = u_reg;
        l_next     = l_reg;
        m_next     = m_reg;
        v_next     = v_reg;
        s_next     = s_reg;
        drain_next = drain_reg;
        ctl        = '0;
        commit     = 1'b0;
        req.ready  = 1'b0;
        k_we       = 1'b0;
        t_we       = 1'b0;
        f_we       = 1'b0;
        f_re       = 1'b0;
        f_waddr    = sq_addr(a_sel, b_sel);
        f_wdata    = req.data_value;

        case (state_reg)
            ST_IDLE:
            begin
                // ready is high here, so valid alone marks an accepted item
                req.ready = 1'b1;
                if (req.valid)
                begin
                    case (op)
                        OP_WRITE_K: k_we = ab_ok && cd_ok;
                        OP_WRITE_T: t_we = ab_ok;
                        OP_WRITE_F: f_we = ab_ok;
                        OP_COMPUTE:
                        begin
                            // pair outside the loop bound: no result, nothing changes
                            if ((a_ext < m_cfg) && (b_ext < m_cfg))
                            begin
                                f_re       = 1'b1;
                                ctl.clear  = 1'b1;
                                u_next     = req.index_a;
                                l_next     = req.index_b;
                                m_next     = m_cfg;
                                v_next     = '0;
                                s_next     = '0;
                                state_next = ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                ctl.issue = 1'b1;
                if (s_last)
                begin
                    s_next = '0;
                    if (v_last)
                    begin
                        drain_next = '0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        v_next = v_reg + SEL_W'(1);
                    end
                end
                else
                begin
                    s_next = s_reg + SEL_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1))
                begin
                    state_next = ST_ROUND;
                end
                else
                begin
                    drain_next = drain_reg + DRAIN_W'(1);
                end
            end
            ST_ROUND:
            begin
                ctl.round_en = 1'b1;
                state_next   = ST_ADDF;
            end
            ST_ADDF:
            begin
                ctl.addf_en = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    f_we       = 1'b1;
                    f_waddr    = sq_addr(u_sel, l_sel);
                    f_wdata    = wb_value;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/antisym_integral_contraction_unit.sv
// antisym_integral_contraction_unit: top level; APB register, memories,
// sequencer, datapath and result register. Depends on aic_pkg, aic_if, aic_ram,
// aic_mac, aic_ctrl.
// Operation: K, T and F writes are accepted directly in the idle state. A
// compute for a pair inside the bound walks one K/T pair per cycle through
// the dual-read K and shared T/F memories, then drains the pipeline, rounds,
// adds F and commits. One item is in work at a time; after a compute the next
// item is taken once its result is committed, which waits until the result
// register is free.
// Reset: rst_n is asynchronous and clears control and sets basis_in_use to 8;
// memory contents are undefined until written and need no clearing pass.
module antisym_integral_contraction_unit import aic_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    // APB-style configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // item channels
    aic_req_if.sink            req,
    aic_rsp_if.source          rsp
);

    logic [CFG_W-1:0]  basis_reg;
    logic              cfg_wr, cfg_hit;

    ctl_t              ctl;
    logic              commit, out_free;
    logic [IDX_W-1:0]  row, col;
    logic [DATA_W-1:0] wb_value;
    logic              wb_sat;

    logic              k_we, t_we, f_we, f_re;
    logic [K_AW-1:0]   k_waddr, k_raddr0, k_raddr1;
    logic [SQ_AW-1:0]  t_waddr, t_raddr0, t_raddr1, f_waddr, f_raddr;
    logic [DATA_W-1:0] f_wdata;
    logic [DATA_W-1:0] k_rd0, k_rd1;

    logic              tf_we, tf_re;
    logic [TF_AW-1:0]  tf_waddr, tf_raddr0, tf_raddr1;
    logic [DATA_W-1:0] tf_wdata, tf_rd0, tf_rd1;
    logic              f_cap_reg;
    logic [DATA_W-1:0] f_hold_reg;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_row_reg, out_col_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_sat_reg;

    // ---------------------------------------------------------------
    // Config register: word-decoded, low two address bits ignored.
    // Writes must land only while idle (system contract, not enforced).
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[PADDR_W-1:2] == REG_BASIS);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;
    assign prdata  = cfg_hit ? PDATA_W'(basis_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_reg <= BASIS_RESET;
        end
        else if (cfg_wr)
        begin
            basis_reg <= pwdata[CFG_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Storage: K tensor in one memory, T and F matrices sharing a
    // second one (T low half, F high half). K and T are read at two
    // mirrored addresses per cycle during the pair walk; F is read once
    // at accept and written back at commit. T writes, the F read and
    // the F write never fall in the same cycle.
    // ---------------------------------------------------------------
    aic_ram #(.WIDTH(DATA_W), .DEPTH(B4)) u_k_ram (
        .clk    (clk),
        .we     (k_we),
        .waddr  (k_waddr),
        .wdata  (req.data_value),
        .re     (ctl.issue),
        .raddr0 (k_raddr0),
        .raddr1 (k_raddr1),
        .rdata0 (k_rd0),
        .rdata1 (k_rd1)
    );

    assign tf_we     = t_we || f_we;
    assign tf_waddr  = t_we ? {1'b0, t_waddr} : {1'b1, f_waddr};
    assign tf_wdata  = t_we ? req.data_value : f_wdata;
    assign tf_re     = ctl.issue || f_re;
    assign tf_raddr0 = f_re ? {1'b1, f_raddr} : {1'b0, t_raddr0};
    assign tf_raddr1 = {1'b0, t_raddr1};

    aic_ram #(.WIDTH(DATA_W), .DEPTH(TF_DEPTH)) u_tf_ram (
        .clk    (clk),
        .we     (tf_we),
        .waddr  (tf_waddr),
        .wdata  (tf_wdata),
        .re     (tf_re),
        .raddr0 (tf_raddr0),
        .raddr1 (tf_raddr1),
        .rdata0 (tf_rd0),
        .rdata1 (tf_rd1)
    );

    // F read data is taken in the cycle after accept, before the first T read
    // overwrites the port, and held until the F add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_cap_reg <= 1'b0;
        end
        else
        begin
            f_cap_reg <= f_re;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_cap_reg)
        begin
            f_hold_reg <= tf_rd0;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer and datapath
    // ---------------------------------------------------------------
    aic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .basis    (basis_reg),
        .req      (req),
        .out_free (out_free),
        .wb_value (wb_value),
        .ctl      (ctl),
        .commit   (commit),
        .row      (row),
        .col      (col),
        .k_we     (k_we),
        .k_waddr  (k_waddr),
        .k_raddr0 (k_raddr0),
        .k_raddr1 (k_raddr1),
        .t_we     (t_we),
        .t_waddr  (t_waddr),
        .t_raddr0 (t_raddr0),
        .t_raddr1 (t_raddr1),
        .f_we     (f_we),
        .f_re     (f_re),
        .f_waddr  (f_waddr),
        .f_wdata  (f_wdata),
        .f_raddr  (f_raddr)
    );

    aic_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .k0       (k_rd0),
        .k1       (k_rd1),
        .t0       (tf_rd0),
        .t1       (tf_rd1),
        .f_in     (f_hold_reg),
        .wb_value (wb_value),
        .wb_sat   (wb_sat)
    );

    // ---------------------------------------------------------------
    // Result register: decouples the result from the request side so
    // writes keep flowing while a result waits; a new commit waits only
    // until the previous result is taken.
    // ---------------------------------------------------------------
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_row_reg   <= row;
            out_col_reg   <= col;
            out_value_reg <= wb_value;
            out_sat_reg   <= wb_sat;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_row   = out_row_reg;
    assign rsp.out_col   = out_col_reg;
    assign rsp.out_value = out_value_reg;
    assign rsp.saturated = out_sat_reg;

endmodule

>>> sim/tb.sv
// tb: self-checking bench for antisym_integral_contraction_unit; loads K, T and F
// entries, issues contraction requests and checks every returned F entry.
// Depends on aic_pkg, aic_if and the unit's RTL.
`timescale 1ns / 1ps

import aic_pkg::*;

localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

typedef struct {
    op_t                      operation;
    logic [IDX_W-1:0]         index_a;
    logic [IDX_W-1:0]         index_b;
    logic [IDX_W-1:0]         index_c;
    logic [IDX_W-1:0]         index_d;
    logic signed [DATA_W-1:0] data_value;
} request_t;

typedef struct {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                     saturated;
} result_t;

// mirror of the tensor stores plus the queue of F entries still owed
class contraction_board;
    logic signed [DATA_W-1:0] k_mem [B4];
    logic signed [DATA_W-1:0] t_mem [B2];
    logic signed [DATA_W-1:0] f_mem [B2];
    bit                       k_set [B4];
    bit                       t_set [B2];
    bit                       f_set [B2];
    logic [CFG_W-1:0]         basis;
    result_t                  due_q [$];
    int                       errors;

    function new();
        basis  = BASIS_RESET;
        errors = 0;
    endfunction

    function int bound();
        return (basis > BASIS_SIZE) ? BASIS_SIZE : int'(basis);
    endfunction

    function int k_slot(int a, int b, int c, int d);
        return ((a * BASIS_SIZE + b) * BASIS_SIZE + c) * BASIS_SIZE + d;
    endfunction

    function int pending();
        return due_q.size();
    endfunction

    function void note_request(request_t r);
        int                       m;
        int                       slot;
        int                       v;
        int                       s;
        logic signed [DATA_W:0]   diff;
        logic signed [DATA_W:0]   tsum;
        logic signed [127:0]      acc;
        result_t                  res;
        slot = r.index_a * BASIS_SIZE + r.index_b;
        case (r.operation)
            OP_WRITE_K:
            begin
                slot = k_slot(r.index_a, r.index_b, r.index_c, r.index_d);
                k_mem[slot] = r.data_value;
                k_set[slot] = 1'b1;
            end
            OP_WRITE_T:
            begin
                t_mem[slot] = r.data_value;
                t_set[slot] = 1'b1;
            end
            OP_WRITE_F:
            begin
                f_mem[slot] = r.data_value;
                f_set[slot] = 1'b1;
            end
            default:
            begin
                m = bound();
                if (r.index_a < m && r.index_b < m)
                begin
                    // exact sum, 2*FRAC_BITS fraction bits
                    acc = '0;
                    for (v = 0; v < m; v++)
                    begin
                        for (s = 0; s < m; s++)
                        begin
                            diff = k_mem[k_slot(r.index_a, v, r.index_b, s)]
                                 - k_mem[k_slot(r.index_a, s, r.index_b, v)];
                            tsum = t_mem[v * BASIS_SIZE + s] + t_mem[s * BASIS_SIZE + v];
                            acc  = acc + diff * tsum * 2;
                        end
                    end
                    // round half up, back to FRAC_BITS, then add the old entry
                    acc = acc + (128'sd1 <<< (FRAC_BITS - 1));
                    acc = acc >>> FRAC_BITS;
                    acc = acc + f_mem[slot];
                    res.out_row   = r.index_a;
                    res.out_col   = r.index_b;
                    res.saturated = 1'b1;
                    if (acc > Q_MAX)
                        res.out_value = Q_MAX;
                    else if (acc < Q_MIN)
                        res.out_value = Q_MIN;
                    else
                    begin
                        res.out_value = acc[DATA_W-1:0];
                        res.saturated = 1'b0;
                    end
                    f_mem[slot] = res.out_value;
                    due_q.insert(due_q.size(), res);
                end
            end
        endcase
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (due_q.size() == 0)
        begin
            $display("%0t: unexpected item: row %0d col %0d value %0d sat %0b",
                     $time, got.out_row, got.out_col, got.out_value, got.saturated);
            errors++;
            return;
        end
        want = due_q.pop_front();
        if (got.out_row !== want.out_row || got.out_col !== want.out_col
            || got.out_value !== want.out_value || got.saturated !== want.saturated)
        begin
            $display("%0t: F mismatch: expected row %0d col %0d value %0d sat %0b, ",
                     $time, want.out_row, want.out_col, want.out_value, want.saturated,
                     "got row %0d col %0d value %0d sat %0b",
                     got.out_row, got.out_col, got.out_value, got.saturated);
            errors++;
        end
    endfunction
endclass

module tb;

    // watchdog limit on the whole run, well above the slowest legal run
    localparam int CYCLE_LIMIT   = 400000;
    // long enough to cover any request still in flight
    localparam int SETTLE_CYCLES = 80;
    // long receiver hold-off used once to back the unit up
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 95;
    localparam logic [PADDR_W-1:0] ADDR_BASIS = PADDR_W'(4 * REG_BASIS);

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    aic_req_if req_ch ();
    aic_rsp_if rsp_ch ();

    antisym_integral_contraction_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    contraction_board sb = new();

    // idle mode per phase: 0 none, 1 sender gaps, 2 receiver stalls, 3 light both
    int       mode = 0;
    bit       hold_request = 1'b0;
    bit       hold_taken = 1'b0;
    int       hold_left = 0;
    int       items_sent = 0;
    int       item_target = 0;
    int       cycle_count = 0;
    int       basis_plan [PHASES] = '{2, 8, 3, 15, 4, 1, 5, 8, 0, 6, 7, 9};
    request_t seen;
    result_t  got;

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int gap_pct(int md);
        return (md == 1) ? 68 : (md == 3) ? 6 : 0;
    endfunction

    function automatic int stall_pct(int md);
        return (md == 2) ? 68 : (md == 3) ? 6 : 0;
    endfunction

    // Result side. A hold-off request is picked up here and counted down
    // locally, so the sender keeps offering while no result can leave.
    always @(negedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct(mode));
    end

    // Both channels sampled at the rising edge. Results are checked before the
    // new request is noted; a request never answers in its own cycle.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.out_row   = rsp_ch.out_row;
                got.out_col   = rsp_ch.out_col;
                got.out_value = rsp_ch.out_value;
                got.saturated = rsp_ch.saturated;
                sb.check_result(got);
            end
            if (req_ch.valid && req_ch.ready)
            begin
                seen.operation  = op_t'(req_ch.operation);
                seen.index_a    = req_ch.index_a;
                seen.index_b    = req_ch.index_b;
                seen.index_c    = req_ch.index_c;
                seen.index_d    = req_ch.index_d;
                seen.data_value = req_ch.data_value;
                sb.note_request(seen);
            end
        end
    end

    function automatic int rand3();
        return $urandom_range(BASIS_SIZE - 1);
    endfunction

    // extremes often, otherwise any 32-bit pattern
    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(7))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '1;
            3: return '0;
            default: return $urandom();
        endcase
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance. valid stays high into the next call unless
    // that call opens with a gap.
    task automatic send(op_t op, int a, int b, int c, int d, logic [DATA_W-1:0] data);
        while ($urandom_range(99) < gap_pct(mode))
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.index_a    <= IDX_W'(a);
        req_ch.index_b    <= IDX_W'(b);
        req_ch.index_c    <= IDX_W'(c);
        req_ch.index_d    <= IDX_W'(d);
        req_ch.data_value <= data;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        items_sent++;
    endtask

    // drop valid, wait for every owed result, then let any silent request finish
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // APB write of the loop bound followed by a read-back
    task automatic write_basis(logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BASIS;
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.basis = value;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[CFG_W-1:0] !== value)
        begin
            $display("%0t: basis_in_use read-back: expected %0d, got %0d",
                     $time, value, prdata[CFG_W-1:0]);
            sb.errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Well-formed sequence: load whatever the (u,l) contraction will read and
    // has never been written, churn a few entries, then request the update.
    task automatic prepare_and_compute(int u, int l);
        int m;
        int v;
        int s;
        m = sb.bound();
        for (v = 0; v < m; v++)
        begin
            for (s = 0; s < m; s++)
            begin
                if (!sb.k_set[sb.k_slot(u, v, l, s)])
                    send(OP_WRITE_K, u, v, l, s, rand_value());
                if (!sb.t_set[v * BASIS_SIZE + s])
                    send(OP_WRITE_T, v, s, rand3(), rand3(), rand_value());
            end
        end
        if (!sb.f_set[u * BASIS_SIZE + l])
            send(OP_WRITE_F, u, l, rand3(), rand3(), rand_value());
        repeat ($urandom_range(2))
            send(OP_WRITE_K, u, $urandom_range(m - 1), l, $urandom_range(m - 1), rand_value());
        if ($urandom_range(3) == 0)
            send(OP_WRITE_T, $urandom_range(m - 1), $urandom_range(m - 1),
                 rand3(), rand3(), rand_value());
        if ($urandom_range(3) == 0)
            send(OP_WRITE_F, u, l, rand3(), rand3(), rand_value());
        send(OP_COMPUTE, u, l, rand3(), rand3(), $urandom());
    endtask

    // Noise: a write anywhere, or a compute outside the loop bound (no result,
    // nothing read).
    task automatic stray_item();
        int m;
        m = sb.bound();
        if (m < BASIS_SIZE && $urandom_range(2) == 0)
        begin
            if (m == 0 || $urandom_range(1) == 0)
                send(OP_COMPUTE, $urandom_range(BASIS_SIZE - 1, m), rand3(),
                     rand3(), rand3(), $urandom());
            else
                send(OP_COMPUTE, rand3(), $urandom_range(BASIS_SIZE - 1, m),
                     rand3(), rand3(), $urandom());
        end
        else
            send(op_t'($urandom_range(2)), rand3(), rand3(), rand3(), rand3(), rand_value());
    endtask

    task automatic random_phase(int count);
        int stop;
        int m;
        int u;
        int l;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            m = sb.bound();
            if (m == 0 || $urandom_range(99) < 20)
                stray_item();
            else
            begin
                // a fresh pair at a large bound costs up to 64 K loads, so big
                // bounds mostly revisit a few pairs
                if (m > 4 && $urandom_range(9) < 7)
                begin
                    u = $urandom_range(1);
                    l = $urandom_range(1);
                end
                else
                begin
                    u = $urandom_range(m - 1);
                    l = $urandom_range(m - 1);
                end
                prepare_and_compute(u, l);
            end
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.operation  <= OP_WRITE_K;
        req_ch.index_a    <= '0;
        req_ch.index_b    <= '0;
        req_ch.index_c    <= '0;
        req_ch.index_d    <= '0;
        req_ch.data_value <= '0;
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Note the (v,s) and (s,v) terms of the contraction
        // carry opposite K differences and equal T sums, so the exact sum is
        // zero and the result is the old F entry; rounding and clipping are
        // then only exercised through exact cancellation of huge partials.
        // Every 3-bit index is inside the built size, so no write is dropped.

        // bound of one: only v = s = 0, whose difference is always zero
        write_basis(CFG_W'(1));
        send(OP_WRITE_K, 0, 0, 0, 0, Q_MIN);
        send(OP_WRITE_T, 0, 0, 7, 7, Q_MAX);
        send(OP_WRITE_F, 0, 0, 7, 7, Q_MIN);
        send(OP_COMPUTE, 0, 0, 0, 0, '0);
        // pair outside the bound, row then column: no result
        send(OP_COMPUTE, 1, 0, 7, 7, '1);
        send(OP_COMPUTE, 0, 7, 0, 0, '0);
        // highest indices everywhere
        send(OP_WRITE_K, 7, 7, 7, 7, Q_MAX);
        send(OP_WRITE_T, 7, 7, 0, 0, '1);
        send(OP_WRITE_F, 7, 7, 0, 0, '1);
        settle();

        // zero bound: no compute answers
        write_basis(CFG_W'(0));
        send(OP_COMPUTE, 0, 0, 0, 0, '0);
        send(OP_COMPUTE, 7, 7, 7, 7, '1);
        settle();

        // bound of two with full-scale opposing entries: partial sums near
        // 2^65 must cancel, and F sits at the top of its range
        write_basis(CFG_W'(2));
        send(OP_WRITE_K, 0, 0, 0, 1, Q_MAX);
        send(OP_WRITE_K, 0, 1, 0, 0, Q_MIN);
        send(OP_WRITE_K, 0, 1, 0, 1, Q_MAX);
        send(OP_WRITE_T, 0, 1, 0, 0, Q_MAX);
        send(OP_WRITE_T, 1, 0, 0, 0, Q_MAX);
        send(OP_WRITE_T, 1, 1, 0, 0, Q_MIN);
        send(OP_WRITE_F, 0, 0, 0, 0, Q_MAX);
        send(OP_COMPUTE, 0, 0, 0, 0, '0);
        settle();

        // Random phases, each with its own bound (past the built size too)
        // and idle pattern; one phase opens with a long receiver hold-off.
        // A running item target absorbs the overshoot of bulk loads, with a
        // quarter phase kept as the minimum.
        item_target = items_sent;
        for (int p = 0; p < PHASES; p++)
        begin
            mode = p % 4;
            write_basis(CFG_W'(basis_plan[p]));
            if (p == 4)
                hold_request = 1'b1;
            item_target = item_target + PHASE_ITEMS;
            random_phase((item_target - items_sent > PHASE_ITEMS / 4)
                         ? item_target - items_sent : PHASE_ITEMS / 4);
            settle();
        end

        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
